/* rtl/ksc_pkg.sv */
// ksc_pkg: shared types, code point constants and the kana vowel class table
// for the kana script converter. No dependencies.
package ksc_pkg;

	localparam int CpW      = 21;
	localparam int ModeW    = 2;
	localparam int VclassW  = 3;
	localparam int TabLen   = 82;
	localparam int TabIdxW  = $clog2(TabLen);
	localparam int ApbDataW = 32;
	localparam int ApbAddrW = 3;

	typedef logic [CpW-1:0]      cpoint_t;
	typedef logic [ModeW-1:0]    mode_t;
	typedef logic [VclassW-1:0]  vclass_t;
	typedef logic [ApbAddrW-1:0] apb_addr_t;
	typedef logic [ApbDataW-1:0] apb_data_t;

	// mode register codes
	localparam mode_t MODE_PASS = 2'd0;
	localparam mode_t MODE_K2H  = 2'd1;
	localparam mode_t MODE_H2K  = 2'd2;

	// register indexes
	localparam logic REG_MODE = 1'b0;

	// vowel classes
	localparam vclass_t VC_NONE = 3'd0;
	localparam vclass_t VC_A    = 3'd1;
	localparam vclass_t VC_I    = 3'd2;
	localparam vclass_t VC_U    = 3'd3;
	localparam vclass_t VC_E    = 3'd4;
	localparam vclass_t VC_O    = 3'd5;

	localparam cpoint_t HIRA_LO    = 21'h03041;
	localparam cpoint_t HIRA_HI    = 21'h03096;
	localparam cpoint_t KATA_LO    = 21'h030A1;
	localparam cpoint_t KATA_HI    = 21'h030F6;
	localparam cpoint_t SMALL_KA   = 21'h030F5;
	localparam cpoint_t SMALL_KE   = 21'h030F6;
	localparam cpoint_t PROLONG    = 21'h030FC;
	localparam cpoint_t KANA_SHIFT = 21'h00060;
	localparam cpoint_t KATA_VU    = 21'h030F4;
	localparam cpoint_t KATA_VA    = 21'h030F7;
	localparam cpoint_t KATA_VI    = 21'h030F8;
	localparam cpoint_t KATA_VE    = 21'h030F9;
	localparam cpoint_t KATA_VO    = 21'h030FA;
	localparam cpoint_t HIRA_A     = 21'h03042;
	localparam cpoint_t HIRA_I     = 21'h03044;
	localparam cpoint_t HIRA_U     = 21'h03046;
	localparam cpoint_t HIRA_E     = 21'h03048;
	localparam cpoint_t HIRA_TAB_END = HIRA_LO + cpoint_t'(TabLen);
	localparam cpoint_t KATA_TAB_END = KATA_LO + cpoint_t'(TabLen);

	// vowel class of the kana at offset i from small a (hiragana or katakana)
	localparam vclass_t VOWEL_TAB [0:TabLen-1] = '{
		VC_A, VC_A, VC_I, VC_I, VC_U, VC_U, VC_E, VC_E, VC_O, VC_O,
		VC_A, VC_A, VC_I, VC_I, VC_U, VC_U, VC_E, VC_E, VC_O, VC_O,
		VC_A, VC_A, VC_I, VC_I, VC_U, VC_U, VC_E, VC_E, VC_O, VC_O,
		VC_A, VC_A, VC_I, VC_I, VC_U, VC_U, VC_U, VC_E, VC_E, VC_O, VC_O,
		VC_A, VC_I, VC_U, VC_E, VC_O,
		VC_A, VC_A, VC_A, VC_I, VC_I, VC_I, VC_U, VC_U, VC_U,
		VC_E, VC_E, VC_E, VC_O, VC_O, VC_O,
		VC_A, VC_I, VC_U, VC_E, VC_O,
		VC_A, VC_A, VC_U, VC_U, VC_O, VC_O,
		VC_A, VC_I, VC_U, VC_E, VC_O,
		VC_A, VC_A, VC_I, VC_E, VC_O
	};

	function automatic vclass_t vowel_of(input cpoint_t c);
		cpoint_t dh;
		cpoint_t dk;
		vclass_t v;
		dh = c - HIRA_LO;
		dk = c - KATA_LO;
		v  = VC_NONE;
		if (c >= HIRA_LO && c < HIRA_TAB_END) begin
			v = VOWEL_TAB[dh[TabIdxW-1:0]];
		end else if (c >= KATA_LO && c < KATA_TAB_END) begin
			v = VOWEL_TAB[dk[TabIdxW-1:0]];
		end else begin
			case (c)
				KATA_VU:  v = VC_U;
				SMALL_KA: v = VC_A;
				SMALL_KE: v = VC_E;
				KATA_VA:  v = VC_A;
				KATA_VI:  v = VC_I;
				KATA_VE:  v = VC_E;
				KATA_VO:  v = VC_O;
				default:  v = VC_NONE;
			endcase
		end
		return v;
	endfunction

endpackage

/* rtl/kana_script_converter_top.sv */
// kana_script_converter_top: kana script converter, input register, conversion
// logic and result register. Depends on ksc_pkg, ksc_cfg and ksc_convert.
//
// Usage:
//   The item channel (item_valid, item_stall, code_point, start_of_text) takes
//   one Unicode code point per transfer; start_of_text marks the first point
//   of a new text and clears the vowel history before it is converted.
//   The result channel (result_valid, result_stall, out_point) gives exactly
//   one converted point per input transfer, in order.
//   The mode register (apb, byte address 0) selects pass through, katakana
//   to hiragana or hiragana to katakana; write it only while the block is idle.
//   An accepted point passes the input register, then the result register,
//   to out_point. Throughput is one point per cycle while result_stall is low,
//   set by the single input-register to result-register path; the vowel class
//   of the last output is the only state carried from one point to the next.
//   When the receiver stalls, the result register holds; one more point may
//   wait in the input register, after which item_stall goes high.
//   Reset clears both valid flags, the vowel history and the mode (pass).
module kana_script_converter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  ksc_pkg::apb_addr_t paddr,
	input  ksc_pkg::apb_data_t pwdata,
	output ksc_pkg::apb_data_t prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  ksc_pkg::cpoint_t   code_point,
	input  logic               start_of_text,
	output logic               result_valid,
	input  logic               result_stall,
	output ksc_pkg::cpoint_t   out_point
);
	import ksc_pkg::*;

	mode_t   mode;
	logic    valid_s1;
	cpoint_t code_s1;
	logic    sot_s1;
	logic    valid_s2;
	cpoint_t point_s2;
	vclass_t prev_class_q;
	vclass_t prev_class;
	cpoint_t conv;
	vclass_t conv_class;
	logic    adv_s2;
	logic    adv_s1;

	ksc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mode    (mode)
	);

	// result register can load when empty or being drained this cycle
	assign adv_s2     = !valid_s2 || !result_stall;
	assign adv_s1     = valid_s1 && adv_s2;
	assign item_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			code_s1 <= code_point;
			sot_s1  <= start_of_text;
		end
	end

	// start of text drops the history for this point
	assign prev_class = sot_s1 ? VC_NONE : prev_class_q;

	ksc_convert u_convert (
		.mode       (mode),
		.code       (code_s1),
		.prev_class (prev_class),
		.conv       (conv),
		.conv_class (conv_class)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			prev_class_q <= VC_NONE;
		end else begin
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				prev_class_q <= conv_class;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			point_s2 <= conv;
		end
	end

	assign result_valid = valid_s2;
	assign out_point    = point_s2;

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && result_stall |-> item_stall)
		else $error("input taken while both stages are full and stalled");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && mode == MODE_PASS |=> out_point == $past(code_s1))
		else $error("pass mode changed a code point");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_stall && !valid_s1 |=> !result_valid)
		else $error("result repeated after transfer");

endmodule

/* rtl/ksc_cfg.sv */
// ksc_cfg: apb register file holding the conversion mode register.
// Depends on ksc_pkg.
module ksc_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  ksc_pkg::apb_addr_t paddr,
	input  ksc_pkg::apb_data_t pwdata,
	output ksc_pkg::apb_data_t prdata,
	output logic               pready,
	output ksc_pkg::mode_t     mode
);
	import ksc_pkg::*;

	mode_t mode_q;
	logic  reg_sel;

	// register index is the word address
	assign reg_sel = paddr[ApbAddrW-1];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PASS;
		end else if (psel && penable && pwrite && pready && reg_sel == REG_MODE) begin
			mode_q <= pwdata[ModeW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel == REG_MODE) begin
			prdata = {{(ApbDataW-ModeW){1'b0}}, mode_q};
		end
	end

	assign mode = mode_q;

endmodule

/* rtl/ksc_convert.sv */
// ksc_convert: converts one code point for the current mode and gives the
// vowel class of the converted point. Depends on ksc_pkg.
module ksc_convert (
	input  ksc_pkg::mode_t   mode,
	input  ksc_pkg::cpoint_t code,
	input  ksc_pkg::vclass_t prev_class,
	output ksc_pkg::cpoint_t conv,
	output ksc_pkg::vclass_t conv_class
);
	import ksc_pkg::*;

	always_comb begin
		conv = code;
		case (mode)
			MODE_K2H: begin
				if (code == SMALL_KA || code == SMALL_KE) begin
					conv = code;
				end else if (code == PROLONG) begin
					// prolonged mark takes the vowel of the previous output, u after an o vowel
					case (prev_class)
						VC_A:    conv = HIRA_A;
						VC_I:    conv = HIRA_I;
						VC_U:    conv = HIRA_U;
						VC_E:    conv = HIRA_E;
						VC_O:    conv = HIRA_U;
						default: conv = code;
					endcase
				end else if (code inside {[KATA_LO:KATA_HI]}) begin
					conv = code - KANA_SHIFT;
				end
			end
			MODE_H2K: begin
				if (code inside {[HIRA_LO:HIRA_HI]}) begin
					conv = code + KANA_SHIFT;
				end
			end
			default: conv = code;
		endcase
	end

	assign conv_class = vowel_of(conv);

endmodule

/* dv/tb_kana_script_converter_top.sv */
// tb_kana_script_converter_top: self-checking testbench for the kana script converter.
// Covers a directed table of edge cases and random kana streams in every mode and idle pattern.
// Depends on ksc_pkg and kana_script_converter_top.
`timescale 1ns / 1ps

module tb_kana_script_converter_top;
	import ksc_pkg::*;

	typedef enum logic [2:0] {V_NONE, V_A, V_I, V_U, V_E, V_O} vowel_e;

	typedef struct {
		mode_t   mode;
		cpoint_t cp;
		logic    sot;
		logic    known;
		cpoint_t want;
	} dir_row_t;

	localparam mode_t   MODE_UNUSED = 2'd3;
	localparam int      TAB_LEN     = 82;
	localparam int      TAB_IDX_W   = $clog2(TAB_LEN);
	localparam int      N_DIR       = 26;
	localparam int      N_PHASES    = 8;
	localparam int      PHASE_ITEMS = 150;
	localparam cpoint_t CP_HIRA_LO  = 21'h03041;
	localparam cpoint_t CP_HIRA_HI  = 21'h03096;
	localparam cpoint_t CP_KATA_LO  = 21'h030A1;
	localparam cpoint_t CP_KATA_HI  = 21'h030F6;
	localparam cpoint_t CP_SMALL_KA = 21'h030F5;
	localparam cpoint_t CP_SMALL_KE = 21'h030F6;
	localparam cpoint_t CP_PROLONG  = 21'h030FC;
	localparam cpoint_t CP_SHIFT    = 21'h00060;
	localparam cpoint_t CP_MAX      = 21'h1FFFFF;
	localparam cpoint_t CP_HIRA_END = CP_HIRA_LO + cpoint_t'(TAB_LEN);
	localparam cpoint_t CP_KATA_END = CP_KATA_LO + cpoint_t'(TAB_LEN);

	// vowel class by offset from small a, same layout for hiragana and katakana
	localparam vowel_e KANA_VOWELS [0:TAB_LEN-1] = '{
		V_A, V_A, V_I, V_I, V_U, V_U, V_E, V_E, V_O, V_O,
		V_A, V_A, V_I, V_I, V_U, V_U, V_E, V_E, V_O, V_O,
		V_A, V_A, V_I, V_I, V_U, V_U, V_E, V_E, V_O, V_O,
		V_A, V_A, V_I, V_I, V_U, V_U, V_U, V_E, V_E, V_O, V_O,
		V_A, V_I, V_U, V_E, V_O,
		V_A, V_A, V_A, V_I, V_I, V_I, V_U, V_U, V_U, V_E, V_E, V_E, V_O, V_O, V_O,
		V_A, V_I, V_U, V_E, V_O,
		V_A, V_A, V_U, V_U, V_O, V_O,
		V_A, V_I, V_U, V_E, V_O,
		V_A, V_A, V_I, V_E, V_O
	};

	logic      clk;
	logic      arst_n        = 1'b0;
	logic      psel          = 1'b0;
	logic      penable       = 1'b0;
	logic      pwrite        = 1'b0;
	apb_addr_t paddr         = '0;
	apb_data_t pwdata        = '0;
	apb_data_t prdata;
	logic      pready;
	logic      item_valid    = 1'b0;
	logic      item_stall;
	cpoint_t   code_point    = '0;
	logic      start_of_text = 1'b0;
	logic      result_valid;
	logic      result_stall  = 1'b0;
	cpoint_t   out_point;

	cpoint_t   expected_points [$];
	mode_t     cur_mode       = MODE_PASS;
	vowel_e    hist_class     = V_NONE;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	int        fail_count     = 0;
	cpoint_t   head_point;

	// mode, code point, start of text, expectation typed in, expected point
	dir_row_t dir_rows [0:N_DIR-1] = '{
		'{MODE_PASS,   21'h000000, 1'b1, 1'b1, 21'h000000},
		'{MODE_PASS,   CP_MAX,     1'b0, 1'b1, CP_MAX},
		'{MODE_PASS,   21'h030AB,  1'b0, 1'b1, 21'h030AB},
		'{MODE_PASS,   CP_PROLONG, 1'b0, 1'b1, CP_PROLONG},
		'{MODE_K2H,    CP_PROLONG, 1'b1, 1'b1, CP_PROLONG},
		'{MODE_K2H,    CP_KATA_LO, 1'b0, 1'b1, CP_HIRA_LO},
		'{MODE_K2H,    CP_PROLONG, 1'b0, 1'b0, '0},
		'{MODE_K2H,    21'h030B7,  1'b0, 1'b0, '0},
		'{MODE_K2H,    CP_PROLONG, 1'b0, 1'b0, '0},
		'{MODE_K2H,    21'h030D5,  1'b0, 1'b0, '0},
		'{MODE_K2H,    CP_PROLONG, 1'b0, 1'b0, '0},
		'{MODE_K2H,    CP_SMALL_KE, 1'b0, 1'b1, CP_SMALL_KE},
		'{MODE_K2H,    CP_PROLONG, 1'b0, 1'b0, '0},
		'{MODE_K2H,    21'h030FA,  1'b0, 1'b0, '0},
		'{MODE_K2H,    CP_PROLONG, 1'b0, 1'b0, '0},
		'{MODE_K2H,    CP_SMALL_KA, 1'b0, 1'b1, CP_SMALL_KA},
		'{MODE_K2H,    21'h030F3,  1'b0, 1'b0, '0},
		'{MODE_K2H,    CP_PROLONG, 1'b0, 1'b0, '0},
		'{MODE_K2H,    21'h030AB,  1'b0, 1'b0, '0},
		'{MODE_K2H,    CP_PROLONG, 1'b1, 1'b1, CP_PROLONG},
		'{MODE_K2H,    CP_MAX,     1'b0, 1'b1, CP_MAX},
		'{MODE_H2K,    CP_HIRA_LO, 1'b1, 1'b1, CP_KATA_LO},
		'{MODE_H2K,    CP_HIRA_HI, 1'b0, 1'b1, CP_KATA_HI},
		'{MODE_H2K,    21'h03097,  1'b0, 1'b1, 21'h03097},
		'{MODE_UNUSED, CP_HIRA_LO, 1'b0, 1'b1, CP_HIRA_LO},
		'{MODE_UNUSED, CP_KATA_LO, 1'b0, 1'b1, CP_KATA_LO}
	};

	mode_t phase_modes [0:N_PHASES-1] = '{
		MODE_K2H, MODE_H2K, MODE_K2H, MODE_UNUSED, MODE_PASS, MODE_K2H, MODE_H2K, MODE_K2H
	};

	kana_script_converter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.code_point    (code_point),
		.start_of_text (start_of_text),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_point     (out_point)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// converts one point under the current mode and carries the vowel history
	function automatic cpoint_t convert_point(input cpoint_t c, input logic sot);
		cpoint_t o;
		cpoint_t d;
		o = c;
		d = '0;
		if (sot) hist_class = V_NONE;
		case (cur_mode)
			MODE_K2H: begin
				if (c == CP_SMALL_KA || c == CP_SMALL_KE) begin
					o = c;
				end else if (c == CP_PROLONG) begin
					case (hist_class)
						V_A:      o = 21'h03042;
						V_I:      o = 21'h03044;
						V_U, V_O: o = 21'h03046;
						V_E:      o = 21'h03048;
						default:  o = c;
					endcase
				end else if (c >= CP_KATA_LO && c <= CP_KATA_HI) begin
					o = c - CP_SHIFT;
				end
			end
			MODE_H2K: begin
				if (c >= CP_HIRA_LO && c <= CP_HIRA_HI) o = c + CP_SHIFT;
			end
			default: ;
		endcase
		if (o >= CP_HIRA_LO && o < CP_HIRA_END) begin
			d = o - CP_HIRA_LO;
			hist_class = KANA_VOWELS[d[TAB_IDX_W-1:0]];
		end else if (o >= CP_KATA_LO && o < CP_KATA_END) begin
			d = o - CP_KATA_LO;
			hist_class = KANA_VOWELS[d[TAB_IDX_W-1:0]];
		end else begin
			case (o)
				21'h030F4: hist_class = V_U;
				21'h030F5: hist_class = V_A;
				21'h030F6: hist_class = V_E;
				21'h030F7: hist_class = V_A;
				21'h030F8: hist_class = V_I;
				21'h030F9: hist_class = V_E;
				21'h030FA: hist_class = V_O;
				default:   hist_class = V_NONE;
			endcase
		end
		return o;
	endfunction

	// mostly kana text with many prolonged marks, some other planes and raw noise
	function automatic cpoint_t rand_point();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 35) return cpoint_t'($urandom_range(32'h30A0, 32'h30FF));
		else if (sel < 50) return CP_PROLONG;
		else if (sel < 68) return cpoint_t'($urandom_range(32'h3040, 32'h309F));
		else if (sel < 76) return cpoint_t'($urandom_range(32'h30F0, 32'h30FF));
		else if (sel < 88) return cpoint_t'($urandom_range(0, 32'hFFFF));
		else return cpoint_t'($urandom);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
	endtask

	task automatic send_item(input cpoint_t cp, input logic sot, input logic known,
			input cpoint_t want);
		cpoint_t pred;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			item_valid    <= 1'b0;
			code_point    <= cpoint_t'($urandom);
			start_of_text <= 1'($urandom);
		end
		@(negedge clk);
		item_valid    <= 1'b1;
		code_point    <= cp;
		start_of_text <= sot;
		do @(posedge clk); while (item_stall);
		pred = convert_point(cp, sot);
		expected_points.push_back(known ? want : pred);
	endtask

	// waits until every pending result has drained before it writes the mode
	task automatic write_mode(input mode_t m);
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= apb_addr_t'(REG_MODE) << 2;
		pwdata  <= apb_data_t'(m);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cur_mode = m;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== apb_data_t'(m)) report_mismatch("mode readback", prdata, 32'(m));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// receiver back-pressure
	initial begin
		forever begin
			@(negedge clk);
			result_stall <= arst_n && ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_points.size() == 0) begin
				report_mismatch("result with nothing pending", 32'(out_point), 0);
			end else begin
				head_point = expected_points.pop_front();
				if (out_point !== head_point)
					report_mismatch("out_point", 32'(out_point), 32'(head_point));
			end
		end
	end

	initial begin
		int wait_cycles;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].mode != cur_mode) write_mode(dir_rows[i].mode);
			send_item(dir_rows[i].cp, dir_rows[i].sot, dir_rows[i].known, dir_rows[i].want);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_mode(phase_modes[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(rand_point(), $urandom_range(0, 15) == 0, 1'b0, '0);
		end

		@(negedge clk);
		item_valid <= 1'b0;
		wait_cycles = 0;
		while (expected_points.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (expected_points.size() != 0)
			report_mismatch("results never delivered", expected_points.size(), 0);
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/ksc_pkg.sv
rtl/ksc_cfg.sv
rtl/ksc_convert.sv
rtl/kana_script_converter_top.sv
dv/tb_kana_script_converter_top.sv
